[hw/rtl/pgrc_pkg.sv]
// Shared types, constants and the division step for the pixel gain block.
// Used by every module under hw/rtl; depends on nothing else.
package pgrc_pkg;

	localparam int BYTE_W     = 8;
	localparam int GAIN_W     = 16;
	localparam int MODE_W     = 2;
	localparam int PROD_W     = BYTE_W + GAIN_W;
	localparam int CFG_W      = GAIN_W;
	localparam int LANES      = 3;
	// Quotient bits resolved per divider stage; the first two come with the clamp stage.
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = BYTE_W / DIV_STEPS - 1;

	// 255.0 in Q16.8: a product above this triggers the ratio-preserving rescale.
	localparam logic [PROD_W-1:0] BYTE_MAX_Q = PROD_W'(255 * 256);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	localparam logic [MODE_W-1:0] MODE_RGB  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RGBX = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PASS = 2'd2;

	localparam logic CFG_GAIN = 1'b0;
	localparam logic CFG_MODE = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

	// One color lane of the divider: running remainder and the word that
	// starts as the low dividend byte and ends as the quotient.
	typedef struct packed {
		byte_t color;
		byte_t rem;
		byte_t acc;
	} lane_t;

	typedef struct packed {
		logic [LANES-1:0][PROD_W-1:0] prod;
		byte_t [LANES-1:0]            color;
		byte_t                        cmax;
		byte_t                        extra;
		logic                         last;
		logic                         pass;
	} mult_t;

	typedef struct packed {
		lane_t [LANES-1:0] lane;
		byte_t             divisor;
		byte_t             extra;
		logic              last;
		logic              clamp;
	} scale_t;

	// One restoring division step: shift in the next dividend bit, subtract
	// the divisor if it fits and shift the quotient bit in at the bottom.
	function automatic lane_t div_step(lane_t l, byte_t d);
		logic [BYTE_W:0] t;
		lane_t           r;
		r = l;
		t = {l.rem, l.acc[BYTE_W-1]};
		if (t >= {1'b0, d}) begin
			r.rem = BYTE_W'(t - {1'b0, d});
			r.acc = {l.acc[BYTE_W-2:0], 1'b1};
		end else begin
			r.rem = t[BYTE_W-1:0];
			r.acc = {l.acc[BYTE_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[hw/rtl/pgrc_mult.sv]
// First stage: gain multiply of the three color bytes, largest byte, mode decode.
// Depends on pgrc_pkg.
module pgrc_mult
	import pgrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [GAIN_W-1:0] gain,
	input  logic [MODE_W-1:0] mode,
	input  logic              up_valid,
	output logic              up_ready,
	input  byte_t             red,
	input  byte_t             green,
	input  byte_t             blue,
	input  byte_t             extra,
	input  logic              last,
	output logic              dn_valid,
	input  logic              dn_ready,
	output mult_t             dn_data
);

	logic  valid_s1;
	mult_t data_s1;
	mult_t data_d;
	byte_t max_rg;

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

	always_comb begin
		max_rg             = (green > red) ? green : red;
		data_d.cmax        = (blue > max_rg) ? blue : max_rg;
		data_d.color[0]    = red;
		data_d.color[1]    = green;
		data_d.color[2]    = blue;
		data_d.prod[0]     = {{GAIN_W{1'b0}}, red} * {{BYTE_W{1'b0}}, gain};
		data_d.prod[1]     = {{GAIN_W{1'b0}}, green} * {{BYTE_W{1'b0}}, gain};
		data_d.prod[2]     = {{GAIN_W{1'b0}}, blue} * {{BYTE_W{1'b0}}, gain};
		data_d.pass        = (mode >= MODE_PASS);
		data_d.last        = last;
		// The fourth byte survives in four-byte and pass-through modes only.
		data_d.extra       = (data_d.pass || mode == MODE_RGBX) ? extra : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= data_d;
		end
	end

endmodule

[hw/rtl/pgrc_clamp.sv]
// Second stage: overflow detection on the largest product, unscaled result
// bytes, dividend setup and the first division steps. Depends on pgrc_pkg.
module pgrc_clamp
	import pgrc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	output logic   up_ready,
	input  mult_t  up_data,
	output logic   dn_valid,
	input  logic   dn_ready,
	output scale_t dn_data
);

	logic              valid_s2;
	scale_t            data_s2;
	scale_t            data_d;
	logic [PROD_W-1:0] pmax;
	logic [PROD_W-1:0] max_01;
	logic [2*BYTE_W-1:0] dividend;
	lane_t             lane;

	assign up_ready = !valid_s2 || dn_ready;
	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

	// With a nonzero gain, p * 255 / pmax equals c * 255 / cmax, so the
	// divider works on the bytes alone.
	always_comb begin
		max_01         = (up_data.prod[1] > up_data.prod[0]) ? up_data.prod[1] : up_data.prod[0];
		pmax           = (up_data.prod[2] > max_01) ? up_data.prod[2] : max_01;
		data_d.clamp   = !up_data.pass && (pmax > BYTE_MAX_Q);
		data_d.divisor = up_data.cmax;
		data_d.extra   = up_data.extra;
		data_d.last    = up_data.last;
		for (int i = 0; i < LANES; i++) begin
			dividend   = {up_data.color[i], {BYTE_W{1'b0}}} -
			             {{BYTE_W{1'b0}}, up_data.color[i]};
			lane.color = up_data.pass ? up_data.color[i]
			                          : up_data.prod[i][2*BYTE_W-1:BYTE_W];
			lane.rem   = dividend[2*BYTE_W-1:BYTE_W];
			lane.acc   = dividend[BYTE_W-1:0];
			for (int s = 0; s < DIV_STEPS; s++) begin
				lane = div_step(lane, up_data.cmax);
			end
			data_d.lane[i] = lane;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= data_d;
		end
	end

endmodule

[hw/rtl/pgrc_div_stage.sv]
// One divider stage: a few restoring division steps on all three lanes.
// Instantiated several times in a row by the top level. Depends on pgrc_pkg.
module pgrc_div_stage
	import pgrc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	output logic   up_ready,
	input  scale_t up_data,
	output logic   dn_valid,
	input  logic   dn_ready,
	output scale_t dn_data
);

	// The _sn registers sit at whichever stage this instance occupies.
	logic   valid_sn;
	scale_t data_sn;
	scale_t data_d;

	assign up_ready = !valid_sn || dn_ready;
	assign dn_valid = valid_sn;
	assign dn_data  = data_sn;

	always_comb begin
		data_d = up_data;
		for (int i = 0; i < LANES; i++) begin
			for (int s = 0; s < DIV_STEPS; s++) begin
				data_d.lane[i] = div_step(data_d.lane[i], up_data.divisor);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (up_ready) begin
			valid_sn <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_sn <= data_d;
		end
	end

endmodule

[hw/rtl/pixel_gain_ratio_clamp.sv]
// Pixel gain with hue-preserving clamp: multiplies R, G and B by one Q8.8 gain
// and, when any channel would pass 255, rescales all three by 255 / largest.
// Depends on pgrc_pkg, pgrc_mult, pgrc_clamp and pgrc_div_stage.
//
// Usage:
//   Input channel: in_valid / in_stall with red_in, green_in, blue_in,
//   extra_in and last_in. An item is taken at an edge with in_valid high and
//   in_stall low. Output channel: out_valid / out_stall with the scaled bytes,
//   extra_out, last_out and clamped.
//   Configuration: cfg_wr_en, cfg_index and cfg_data write gain (index 0) or
//   the pixel mode (index 1); write them only while no item is inside.
//   Throughput is one item per clock while out_stall is low. There is one
//   multiply stage, one clamp stage, then three divider stages, each resolving
//   two bits of the 8-bit rescale quotient; the last stage register drives the
//   outputs. Every stage has its own valid bit, so bubbles close up while the
//   output is stalled. in_stall rises only once all five stages hold items and
//   the receiver stalls. Reset empties the pipeline, sets the gain to unity and
//   selects three-byte pixels.
module pixel_gain_ratio_clamp
	import pgrc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  byte_t            red_in,
	input  byte_t            green_in,
	input  byte_t            blue_in,
	input  byte_t            extra_in,
	input  logic             last_in,
	output logic             out_valid,
	input  logic             out_stall,
	output byte_t            red_out,
	output byte_t            green_out,
	output byte_t            blue_out,
	output byte_t            extra_out,
	output logic             last_out,
	output logic             clamped
);

	logic [GAIN_W-1:0]   gain_q;
	logic [MODE_W-1:0]   mode_q;
	logic                in_ready;
	logic                mult_valid;
	logic                mult_ready;
	mult_t               mult_data;
	logic [DIV_STAGES:0] stage_valid;
	logic [DIV_STAGES:0] stage_ready;
	scale_t              stage_data [DIV_STAGES+1];
	scale_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			mode_q <= MODE_RGB;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_GAIN: gain_q <= cfg_data;
				CFG_MODE: mode_q <= cfg_data[MODE_W-1:0];
				default:  gain_q <= gain_q;
			endcase
		end
	end

	pgrc_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (gain_q),
		.mode     (mode_q),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.red      (red_in),
		.green    (green_in),
		.blue     (blue_in),
		.extra    (extra_in),
		.last     (last_in),
		.dn_valid (mult_valid),
		.dn_ready (mult_ready),
		.dn_data  (mult_data)
	);

	pgrc_clamp u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mult_valid),
		.up_ready (mult_ready),
		.up_data  (mult_data),
		.dn_valid (stage_valid[0]),
		.dn_ready (stage_ready[0]),
		.dn_data  (stage_data[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		pgrc_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stage_valid[i]),
			.up_ready (stage_ready[i]),
			.up_data  (stage_data[i]),
			.dn_valid (stage_valid[i+1]),
			.dn_ready (stage_ready[i+1]),
			.dn_data  (stage_data[i+1])
		);
	end

	assign in_stall                = !in_ready;
	assign stage_ready[DIV_STAGES] = !out_stall;
	assign out_valid               = stage_valid[DIV_STAGES];
	assign res                     = stage_data[DIV_STAGES];

	assign red_out   = res.clamp ? res.lane[0].acc : res.lane[0].color;
	assign green_out = res.clamp ? res.lane[1].acc : res.lane[1].color;
	assign blue_out  = res.clamp ? res.lane[2].acc : res.lane[2].color;
	assign extra_out = res.extra;
	assign last_out  = res.last;
	assign clamped   = res.clamp;

	// The input side can only back up when the whole pipeline is full and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the pipeline can still move");

	// After a rescale the largest channel lands on exactly 255.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clamped) |->
		(red_out == 8'hFF || green_out == 8'hFF || blue_out == 8'hFF))
		else $error("rescaled pixel has no channel at full scale");

	// Pass-through pixels never carry a rescale.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clamped) |-> (mode_q < MODE_PASS))
		else $error("rescale flagged in pass-through mode");

endmodule
